// ----- rtl/dual_axis_light_tracker_defines.svh -----
// Assertion macros used by the tracker top level.
`ifndef DUAL_AXIS_LIGHT_TRACKER_DEFINES_SVH
`define DUAL_AXIS_LIGHT_TRACKER_DEFINES_SVH

// Checked property, disabled while reset is asserted (active low).
`define DALT_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds during reset.
`define DALT_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/dalt_pkg.sv -----
// Types and constants of the dual axis light tracker.
`default_nettype none
package dalt_pkg;

    typedef enum logic [2:0] {
        CMD_SAMPLE = 3'd0,
        CMD_MODE   = 3'd1,
        CMD_RIGHT  = 3'd2,
        CMD_LEFT   = 3'd3,
        CMD_UP     = 3'd4,
        CMD_DOWN   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        REG_THRESHOLD   = 2'd0,
        REG_MAX_ADJUST  = 2'd1,
        REG_MANUAL_STEP = 2'd2
    } t_reg_idx;

    localparam int LIGHT_W = 16;
    localparam int VERT_W  = 14;
    localparam int HORZ_W  = 15;
    localparam int STEP_W  = 14;
    localparam int CFG_W   = 16;

    // angle limits, hundredths of a degree
    localparam int V_MAX = 9000;
    localparam int H_MIN = -9000;
    localparam int H_MAX = 9000;

    localparam logic [15:0] THR_RESET  = 16'd5;
    localparam logic [13:0] ADJ_RESET  = 14'd500;
    localparam logic [13:0] STEP_RESET = 14'd500;
    localparam logic [13:0] TRK_V_RESET = 14'd9000;

    typedef struct packed {
        logic [15:0] threshold;
        logic [13:0] max_adjust;
        logic [13:0] manual_step;
    } t_cfg;

    typedef struct packed {
        logic              manual_active;
        logic              move_issued;
        logic signed [14:0] horizontal_target;
        logic [13:0]       vertical_target;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/dalt_axis.sv -----
// One automatic adjustment of a tracked angle from a doubled light difference.
`default_nettype none
module dalt_axis #(
    parameter int LO      = 0,
    parameter int HI      = 9000,
    parameter bit LO_INCL = 1'b0
) (
    input  wire logic signed [15:0] i_cur,
    input  wire logic signed [17:0] i_diff,
    input  wire logic        [15:0] i_thr,
    input  wire logic        [13:0] i_max_adj,
    output logic signed      [15:0] o_next
);
    localparam logic signed [15:0] Lo = 16'(LO);
    localparam logic signed [15:0] Hi = 16'(HI);

    logic        [16:0] mag;
    logic        [16:0] thr2;
    logic        [19:0] step_full;
    logic        [13:0] step;
    logic signed [15:0] step_s;
    logic signed [15:0] nv;
    logic               in_range;

    always_comb begin
        mag       = i_diff[17] ? 17'(-i_diff) : i_diff[16:0];
        thr2      = {i_thr, 1'b0};
        step_full = {1'b0, mag, 2'b00} + {3'b000, mag};
        step      = (step_full > {6'd0, i_max_adj}) ? i_max_adj : step_full[13:0];
        step_s    = $signed({2'b00, step});
        nv        = i_cur;
        if (!i_diff[17] && (i_diff != '0) && (i_cur < Hi)) begin
            nv = i_cur + step_s;
        end else if (i_diff[17] && (i_cur > Lo)) begin
            nv = i_cur - step_s;
        end
        if (LO_INCL) begin
            in_range = (nv >= Lo) && (nv <= Hi);
        end else begin
            in_range = (nv > Lo) && (nv < Hi);
        end
        if (mag <= thr2) begin
            o_next = i_cur;
        end else begin
            o_next = in_range ? nv : i_cur;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/dalt_ctrl.sv -----
// Tracker state, command decode and next-state logic for one request.
`default_nettype none
module dalt_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire dalt_pkg::t_cmd       i_cmd,
    input  wire logic [15:0]          i_tl,
    input  wire logic [15:0]          i_tr,
    input  wire logic [15:0]          i_bl,
    input  wire logic [15:0]          i_br,
    input  wire dalt_pkg::t_cfg       i_cfg,
    output dalt_pkg::t_result         o_result,
    output logic                      o_mode
);
    logic               r_mode,  n_mode;
    logic        [13:0] r_trk_v, n_trk_v;
    logic signed [14:0] r_trk_h, n_trk_h;
    logic        [13:0] r_mot_v, n_mot_v;
    logic signed [14:0] r_mot_h, n_mot_h;
    logic               moved;

    logic        [16:0] sum_top, sum_bot, sum_lft, sum_rgt;
    logic signed [17:0] diff_v, diff_h;
    logic signed [15:0] adj_v, adj_h;
    logic signed [16:0] man_h_up, man_h_dn, man_v_up, man_v_dn;
    logic signed [16:0] step_s;

    always_comb begin
        sum_top = {1'b0, i_tl} + {1'b0, i_tr};
        sum_bot = {1'b0, i_bl} + {1'b0, i_br};
        sum_lft = {1'b0, i_tl} + {1'b0, i_bl};
        sum_rgt = {1'b0, i_tr} + {1'b0, i_br};
        diff_v  = $signed({1'b0, sum_bot}) - $signed({1'b0, sum_top});
        diff_h  = $signed({1'b0, sum_rgt}) - $signed({1'b0, sum_lft});
    end

    dalt_axis #(.LO(0), .HI(dalt_pkg::V_MAX), .LO_INCL(1'b0)) u_axis_v (
        .i_cur     ($signed({2'b00, r_trk_v})),
        .i_diff    (diff_v),
        .i_thr     (i_cfg.threshold),
        .i_max_adj (i_cfg.max_adjust),
        .o_next    (adj_v)
    );

    dalt_axis #(.LO(dalt_pkg::H_MIN), .HI(dalt_pkg::H_MAX), .LO_INCL(1'b1)) u_axis_h (
        .i_cur     (16'(r_trk_h)),
        .i_diff    (diff_h),
        .i_thr     (i_cfg.threshold),
        .i_max_adj (i_cfg.max_adjust),
        .o_next    (adj_h)
    );

    always_comb begin
        step_s   = $signed({3'b000, i_cfg.manual_step});
        man_h_up = 17'(r_mot_h) + step_s;
        man_h_dn = 17'(r_mot_h) - step_s;
        man_v_up = $signed({3'b000, r_mot_v}) + step_s;
        man_v_dn = $signed({3'b000, r_mot_v}) - step_s;

        n_mode  = r_mode;
        n_trk_v = r_trk_v;
        n_trk_h = r_trk_h;
        n_mot_v = r_mot_v;
        n_mot_h = r_mot_h;
        moved   = 1'b0;
        case (i_cmd)
            dalt_pkg::CMD_SAMPLE: begin
                if (!r_mode) begin
                    n_trk_v = adj_v[13:0];
                    n_trk_h = adj_h[14:0];
                    n_mot_v = adj_v[13:0];
                    n_mot_h = adj_h[14:0];
                    moved   = 1'b1;
                end
            end
            dalt_pkg::CMD_MODE: begin
                n_mode = !r_mode;
            end
            dalt_pkg::CMD_RIGHT: begin
                if (r_mode) begin
                    n_mot_h = (man_h_up > 17'(dalt_pkg::H_MAX)) ?
                              15'(dalt_pkg::H_MAX) : man_h_up[14:0];
                    moved   = 1'b1;
                end
            end
            dalt_pkg::CMD_LEFT: begin
                if (r_mode) begin
                    n_mot_h = (man_h_dn < 17'(dalt_pkg::H_MIN)) ?
                              15'(dalt_pkg::H_MIN) : man_h_dn[14:0];
                    moved   = 1'b1;
                end
            end
            dalt_pkg::CMD_UP: begin
                if (r_mode) begin
                    n_mot_v = (man_v_up > 17'(dalt_pkg::V_MAX)) ?
                              14'(dalt_pkg::V_MAX) : man_v_up[13:0];
                    moved   = 1'b1;
                end
            end
            dalt_pkg::CMD_DOWN: begin
                if (r_mode) begin
                    n_mot_v = man_v_dn[16] ? 14'd0 : man_v_dn[13:0];
                    moved   = 1'b1;
                end
            end
            default: begin
                // unused codes leave everything as is
            end
        endcase

        o_result.vertical_target   = n_mot_v;
        o_result.horizontal_target = n_mot_h;
        o_result.move_issued       = moved;
        o_result.manual_active     = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_trk_v <= dalt_pkg::TRK_V_RESET;
            r_trk_h <= '0;
            r_mot_v <= '0;
            r_mot_h <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_trk_v <= n_trk_v;
            r_trk_h <= n_trk_h;
            r_mot_v <= n_mot_v;
            r_mot_h <= n_mot_h;
        end
    end

    assign o_mode = r_mode;
endmodule
`default_nettype wire

// ----- rtl/dual_axis_light_tracker.sv -----
// Top level of the dual axis light tracker: handshakes, config and result registers.
// Usage:
//  Slave stream (s_axis_*): one request per beat. tuser carries the command
//  (0 light sample, 1 mode button, 2 right, 3 left, 4 up, 5 down); tdata
//  carries the four quadrant readings in lux.
//  Master stream (m_axis_*): exactly one result per request, in order, with both
//  motor targets, a move flag and the current mode.
//  Config channel (i_cfg_valid / o_cfg_ready, index and data): always ready.
//  Write only while the block is idle.
//  Pipeline: a request is held in the input register, then in the result register.
//  Throughput: one request per cycle while the receiver keeps m_axis_tready high.
//  The tracker state updates when a request moves from the input register to
//  the result register, so each request sees the state left by the previous.
//  Reset (synchronous, active low): auto mode, tracked angles 90.00 / 0.00 deg,
//  motor targets 0, threshold 5, max adjust 500, manual step 500, both
//  stream registers empty.
//  Receiver stall: the result holds; the input register still takes one more
//  request, after which s_axis_tready drops until the result is taken.
`default_nettype none
module dual_axis_light_tracker #(
    parameter int LIGHT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: ul_lux[15:0], ur_lux[31:16], ll_lux[47:32], lr_lux[63:48]
    input  wire logic [63:0] s_axis_tdata,
    // tuser: cmd[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    // master stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: vertical_target[13:0], horizontal_target[28:14], move_issued[29],
    // manual_active[30], zero pad[31]
    output logic [31:0]      m_axis_tdata,
    // config write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    `include "dual_axis_light_tracker_defines.svh"

    localparam logic [15:0] LightMask =
        (LIGHT_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << LIGHT_BITS) - 32'd1);

    dalt_pkg::t_cfg    r_cfg;
    logic              r_in_valid;
    dalt_pkg::t_cmd    r_in_cmd;
    logic [15:0]       r_tl, r_tr, r_bl, r_br;
    logic              r_out_valid;
    dalt_pkg::t_result r_out;
    dalt_pkg::t_result n_out;
    logic              advance;
    logic              in_fire;
    logic              mode;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold   <= dalt_pkg::THR_RESET;
            r_cfg.max_adjust  <= dalt_pkg::ADJ_RESET;
            r_cfg.manual_step <= dalt_pkg::STEP_RESET;
        end else if (i_cfg_valid) begin
            case (dalt_pkg::t_reg_idx'(i_cfg_index))
                dalt_pkg::REG_THRESHOLD:   r_cfg.threshold   <= i_cfg_data;
                dalt_pkg::REG_MAX_ADJUST:  r_cfg.max_adjust  <= i_cfg_data[13:0];
                dalt_pkg::REG_MANUAL_STEP: r_cfg.manual_step <= i_cfg_data[13:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_cmd <= dalt_pkg::t_cmd'(s_axis_tuser);
            r_tl     <= s_axis_tdata[15:0]  & LightMask;
            r_tr     <= s_axis_tdata[31:16] & LightMask;
            r_bl     <= s_axis_tdata[47:32] & LightMask;
            r_br     <= s_axis_tdata[63:48] & LightMask;
        end
    end

    dalt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_cmd    (r_in_cmd),
        .i_tl     (r_tl),
        .i_tr     (r_tr),
        .i_bl     (r_bl),
        .i_br     (r_br),
        .i_cfg    (r_cfg),
        .o_result (n_out),
        .o_mode   (mode)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

    `DALT_ASSERT_RST(a_vert_range, i_clk, i_rst_n,
        r_out_valid |-> (r_out.vertical_target <= 14'(dalt_pkg::V_MAX)),
        "vertical target out of range")
    `DALT_ASSERT_RST(a_horz_range, i_clk, i_rst_n,
        r_out_valid |-> ((r_out.horizontal_target <= 15'(dalt_pkg::H_MAX)) &&
                         (r_out.horizontal_target >= 15'(dalt_pkg::H_MIN))),
        "horizontal target out of range")
    `DALT_ASSERT_RST(a_mode_toggle, i_clk, i_rst_n,
        (advance && (r_in_cmd == dalt_pkg::CMD_MODE)) |=>
            (r_out_valid && !r_out.move_issued && (mode != $past(mode)) &&
             (r_out.manual_active == mode)),
        "mode button did not toggle cleanly")
    `DALT_ASSERT(a_ready_full, i_clk,
        (i_rst_n && !s_axis_tready) |-> (r_in_valid && r_out_valid),
        "input stalled without both registers full")
endmodule
`default_nettype wire
